// ===== hw/rtl/pwc_pkg.sv =====
// shared types and constants of the pulsed watering controller
`default_nettype none

package pwc_pkg;

  // register index and data widths of the configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // field widths
  localparam int PCT_W   = 7;
  localparam int DUR_W   = 32;
  localparam int COUNT_W = 4;

  // default time stamp width
  localparam int TIME_BITS_DEF = 32;

  // percent ceiling of the stop level
  localparam logic [PCT_W:0] PCT_MAX = 8'd100;
  // pulses before the moisture rise is judged
  localparam logic [COUNT_W-1:0] RISE_PULSES = 4'd2;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 4'd15;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_THRESHOLD  = 3'd0,
    CFG_STOP_HYSTERESIS  = 3'd1,
    CFG_PULSE_TIME       = 3'd2,
    CFG_SOAK_TIME        = 3'd3,
    CFG_PULSE_LIMIT      = 3'd4,
    CFG_MIN_RISE         = 3'd5,
    CFG_SAMPLE_INTERVAL  = 3'd6,
    CFG_AUTO_ENABLE      = 3'd7
  } cfg_idx_t;

  // register defaults after reset
  localparam logic [PCT_W-1:0]   START_THRESHOLD_RST = 7'd40;
  localparam logic [PCT_W-1:0]   STOP_HYSTERESIS_RST = 7'd10;
  localparam logic [DUR_W-1:0]   PULSE_TIME_RST      = 32'd5000;
  localparam logic [DUR_W-1:0]   SOAK_TIME_RST       = 32'd60000;
  localparam logic [COUNT_W-1:0] PULSE_LIMIT_RST     = 4'd5;
  localparam logic [PCT_W-1:0]   MIN_RISE_RST        = 7'd3;
  localparam logic [DUR_W-1:0]   SAMPLE_INTERVAL_RST = 32'd10000;
  localparam logic               AUTO_ENABLE_RST     = 1'b1;

  // controller modes
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_WATER = 3'd1,
    MODE_SOAK  = 3'd2,
    MODE_LOCK  = 3'd3,
    MODE_ESTOP = 3'd4
  } mode_t;

  // fault codes
  typedef enum logic [1:0] {
    FAULT_NONE   = 2'd0,
    FAULT_LIMIT  = 2'd1,
    FAULT_NORISE = 2'd2
  } fault_t;

  // one result item
  typedef struct packed {
    mode_t              mode;
    logic               pump_on;
    logic [COUNT_W-1:0] pulses_done;
    fault_t             fault;
    logic               available;
    logic               report_due;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pulsed_watering_controller.sv =====
// top level of the pulsed watering controller
`default_nettype none

// Pulsed watering controller. Each input item is one control-loop pass (time stamp,
// moisture reading, e-stop and service flags) and yields exactly one result item.
// The whole pass (e-stop, end of pulse, service cancel, sample decision and automatic
// start) is evaluated in the cycle the item is accepted, so one item per clock is
// sustained while the skid register is empty; results are registered in a two-entry
// output buffer (result register plus skid register) that lets one more item in while
// a result waits. Registers are written via cfg_we/cfg_index/cfg_data, by the user only
// while the block is idle (not enforced by the block); indexes without a register are
// ignored. Time differences wrap modulo 2^TIME_BITS; E-stop is left only through reset.
module pulsed_watering_controller #(
  parameter int TIME_BITS = pwc_pkg::TIME_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [pwc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pwc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [TIME_BITS-1:0]              now_ms,
  input  wire logic [pwc_pkg::PCT_W-1:0]         moisture_percent,
  input  wire logic                              estop_held,
  input  wire logic                              ota_command_pending,
  input  wire logic                              ota_busy,
  input  wire logic                              calibration_command_pending,
  input  wire logic                              calibration_active,
  input  wire logic                              evaluation_command_pending,
  input  wire logic                              evaluation_active,
  // output channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output pwc_pkg::mode_t                         mode,
  output logic                                   pump_on,
  output logic [pwc_pkg::COUNT_W-1:0]            pulses_done,
  output pwc_pkg::fault_t                        fault,
  output logic                                   available,
  output logic                                   report_due
);

  import pwc_pkg::*;

  // compare width covers both the wrapped elapsed time and a 32-bit duration
  localparam int CMP_W = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;

  // configuration registers
  logic [PCT_W-1:0]   start_threshold_percent;
  logic [PCT_W-1:0]   stop_hysteresis_percent;
  logic [DUR_W-1:0]   pulse_time_ms;
  logic [DUR_W-1:0]   soak_time_ms;
  logic [COUNT_W-1:0] pulse_limit;
  logic [PCT_W-1:0]   min_rise_percent;
  logic [DUR_W-1:0]   sample_interval_ms;
  logic               auto_enable;

  // controller state
  mode_t              mode_reg, mode_next;
  logic [COUNT_W-1:0] pulse_count, pulse_count_next;
  fault_t             fault_kind, fault_kind_next;
  logic [TIME_BITS-1:0] pulse_start_time, pulse_start_time_next;
  logic [TIME_BITS-1:0] soak_start_time, soak_start_time_next;
  logic [TIME_BITS-1:0] last_sample_time, last_sample_time_next;
  logic [PCT_W-1:0]   cycle_start_percent, cycle_start_percent_next;
  logic               sample_seen, sample_seen_next;

  // pass evaluation
  logic [TIME_BITS-1:0] pulse_elapsed, soak_elapsed, sample_elapsed;
  logic                 pulse_over, soak_over, sample_due;
  logic [PCT_W:0]       level_sum, stop_level, rise_level;
  logic                 cancel, inhibited, report;
  result_t              result;

  // output buffer
  result_t out_reg, skid_reg;
  logic    skid_valid;
  logic    push, pop;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_threshold_percent <= START_THRESHOLD_RST;
      stop_hysteresis_percent <= STOP_HYSTERESIS_RST;
      pulse_time_ms           <= PULSE_TIME_RST;
      soak_time_ms            <= SOAK_TIME_RST;
      pulse_limit             <= PULSE_LIMIT_RST;
      min_rise_percent        <= MIN_RISE_RST;
      sample_interval_ms      <= SAMPLE_INTERVAL_RST;
      auto_enable             <= AUTO_ENABLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START_THRESHOLD: start_threshold_percent <= cfg_data[PCT_W-1:0];
        CFG_STOP_HYSTERESIS: stop_hysteresis_percent <= cfg_data[PCT_W-1:0];
        CFG_PULSE_TIME:      pulse_time_ms           <= cfg_data[DUR_W-1:0];
        CFG_SOAK_TIME:       soak_time_ms            <= cfg_data[DUR_W-1:0];
        CFG_PULSE_LIMIT:     pulse_limit             <= cfg_data[COUNT_W-1:0];
        CFG_MIN_RISE:        min_rise_percent        <= cfg_data[PCT_W-1:0];
        CFG_SAMPLE_INTERVAL: sample_interval_ms      <= cfg_data[DUR_W-1:0];
        CFG_AUTO_ENABLE:     auto_enable             <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // levels derived from the registers
  always_comb begin
    level_sum  = {1'b0, start_threshold_percent} + {1'b0, stop_hysteresis_percent};
    stop_level = (level_sum > PCT_MAX) ? PCT_MAX : level_sum;
    rise_level = {1'b0, cycle_start_percent} + {1'b0, min_rise_percent};
  end

  // one control pass over the accepted item
  always_comb begin
    mode_next                = mode_reg;
    pulse_count_next         = pulse_count;
    fault_kind_next          = fault_kind;
    pulse_start_time_next    = pulse_start_time;
    soak_start_time_next     = soak_start_time;
    last_sample_time_next    = last_sample_time;
    cycle_start_percent_next = cycle_start_percent;
    sample_seen_next         = sample_seen;
    report                   = 1'b0;

    // emergency stop
    if (estop_held && mode_reg != MODE_ESTOP) begin
      mode_next = MODE_ESTOP;
      report    = 1'b1;
    end

    // end of a pulse
    pulse_elapsed = now_ms - pulse_start_time;
    pulse_over    = CMP_W'(pulse_elapsed) >= CMP_W'(pulse_time_ms);
    if (mode_next == MODE_WATER && pulse_over) begin
      if (pulse_count_next < COUNT_MAX) begin
        pulse_count_next = pulse_count_next + 1'b1;
      end
      soak_start_time_next = now_ms;
      mode_next            = MODE_SOAK;
      report               = 1'b1;
    end

    // service commands cancel a running cycle
    cancel = ota_command_pending || calibration_command_pending ||
             evaluation_command_pending;
    if (cancel && (mode_next == MODE_WATER || mode_next == MODE_SOAK)) begin
      mode_next        = MODE_IDLE;
      pulse_count_next = '0;
      fault_kind_next  = FAULT_NONE;
      report           = 1'b1;
    end

    // sample decision and automatic start
    inhibited = ota_busy || ota_command_pending || calibration_active ||
                calibration_command_pending || evaluation_active ||
                evaluation_command_pending;
    sample_elapsed = now_ms - last_sample_time;
    sample_due     = !sample_seen ||
                     (CMP_W'(sample_elapsed) >= CMP_W'(sample_interval_ms));
    soak_elapsed   = now_ms - soak_start_time_next;
    soak_over      = CMP_W'(soak_elapsed) >= CMP_W'(soak_time_ms);
    if (sample_due) begin
      last_sample_time_next = now_ms;
      sample_seen_next      = 1'b1;
      if (mode_next == MODE_SOAK && soak_over) begin
        if ({1'b0, moisture_percent} >= stop_level) begin
          mode_next        = MODE_IDLE;
          pulse_count_next = '0;
          fault_kind_next  = FAULT_NONE;
        end else if (pulse_count_next >= pulse_limit) begin
          mode_next       = MODE_LOCK;
          fault_kind_next = FAULT_LIMIT;
        end else if (pulse_count_next >= RISE_PULSES &&
                     {1'b0, moisture_percent} < rise_level) begin
          mode_next       = MODE_LOCK;
          fault_kind_next = FAULT_NORISE;
        end else begin
          mode_next             = MODE_WATER;
          pulse_start_time_next = now_ms;
        end
      end else if (mode_next == MODE_LOCK && {1'b0, moisture_percent} >= stop_level) begin
        mode_next        = MODE_IDLE;
        pulse_count_next = '0;
        fault_kind_next  = FAULT_NONE;
      end
      if (auto_enable && !inhibited && mode_next == MODE_IDLE &&
          moisture_percent < start_threshold_percent) begin
        cycle_start_percent_next = moisture_percent;
        pulse_count_next         = '0;
        fault_kind_next          = FAULT_NONE;
        mode_next                = MODE_WATER;
        pulse_start_time_next    = now_ms;
      end
      report = 1'b1;
    end

    // result fields
    result.mode        = mode_next;
    result.pump_on     = (mode_next == MODE_WATER);
    result.pulses_done = pulse_count_next;
    result.fault       = fault_kind_next;
    result.available   = (mode_next == MODE_IDLE) || (mode_next == MODE_LOCK);
    result.report_due  = report;
  end

  // handshake
  assign in_ready = !skid_valid;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  // state update on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg            <= MODE_IDLE;
      pulse_count         <= '0;
      fault_kind          <= FAULT_NONE;
      pulse_start_time    <= '0;
      soak_start_time     <= '0;
      last_sample_time    <= '0;
      cycle_start_percent <= '0;
      sample_seen         <= 1'b0;
    end else if (push) begin
      mode_reg            <= mode_next;
      pulse_count         <= pulse_count_next;
      fault_kind          <= fault_kind_next;
      pulse_start_time    <= pulse_start_time_next;
      soak_start_time     <= soak_start_time_next;
      last_sample_time    <= last_sample_time_next;
      cycle_start_percent <= cycle_start_percent_next;
      sample_seen         <= sample_seen_next;
    end
  end

  // output buffer valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // output buffer payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_reg <= skid_reg;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_reg <= result;
      end else begin
        out_reg <= result;
      end
    end
  end

  // result ports
  assign mode        = out_reg.mode;
  assign pump_on     = out_reg.pump_on;
  assign pulses_done = out_reg.pulses_done;
  assign fault       = out_reg.fault;
  assign available   = out_reg.available;
  assign report_due  = out_reg.report_due;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// testbench of the pulsed watering controller: stimulus, mode predictor and result checks
module tb;
  import pwc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  // service and stop flags of one pass, packed in the order of the pass fields
  localparam logic [6:0] F_NONE      = 7'b0000000;
  localparam logic [6:0] F_ESTOP     = 7'b1000000;
  localparam logic [6:0] F_OTA_PEND  = 7'b0100000;
  localparam logic [6:0] F_OTA_BUSY  = 7'b0010000;
  localparam logic [6:0] F_CAL_PEND  = 7'b0001000;
  localparam logic [6:0] F_CAL_ACT   = 7'b0000100;
  localparam logic [6:0] F_EVAL_PEND = 7'b0000010;
  localparam logic [6:0] F_EVAL_ACT  = 7'b0000001;

  // one control-loop pass
  typedef struct packed {
    logic [DUR_W-1:0] now;
    logic [PCT_W-1:0] moist;
    logic             estop;
    logic             ota_pend;
    logic             ota_busy;
    logic             cal_pend;
    logic             cal_act;
    logic             eval_pend;
    logic             eval_act;
  } pass_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_index = CFG_START_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  pass_t                 cur_pass = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  mode_t                 mode;
  logic                  pump_on;
  logic [COUNT_W-1:0]    pulses_done;
  fault_t                fault;
  logic                  available;
  logic                  report_due;

  // pending passes and expected status items
  pass_t   pass_q[$];
  result_t status_q[$];
  result_t want;
  int      errors = 0;

  // sender bursts and receiver stall pattern
  int          burst_left = 1;
  int          gap_left = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  int          pat_step = 0;
  logic [31:0] clock_ms = 32'd0;

  // predictor copy of the configuration
  logic [PCT_W-1:0]   thr_pct;
  logic [PCT_W-1:0]   hyst_pct;
  logic [DUR_W-1:0]   pulse_ms;
  logic [DUR_W-1:0]   soak_ms;
  logic [COUNT_W-1:0] limit_cnt;
  logic [PCT_W-1:0]   rise_pct;
  logic [DUR_W-1:0]   interval_ms;
  logic               auto_en;

  // predictor copy of the controller state
  mode_t              ctl_mode;
  logic [COUNT_W-1:0] ctl_pulses;
  fault_t             ctl_fault;
  logic [DUR_W-1:0]   ctl_pulse_t0;
  logic [DUR_W-1:0]   ctl_soak_t0;
  logic [DUR_W-1:0]   ctl_sample_t0;
  logic [PCT_W-1:0]   ctl_start_pct;
  logic               ctl_sampled;

  pulsed_watering_controller dut (
    .clk                         (clk),
    .rst                         (rst),
    .cfg_we                      (cfg_we),
    .cfg_index                   (cfg_index),
    .cfg_data                    (cfg_data),
    .in_valid                    (in_valid),
    .in_ready                    (in_ready),
    .now_ms                      (cur_pass.now),
    .moisture_percent            (cur_pass.moist),
    .estop_held                  (cur_pass.estop),
    .ota_command_pending         (cur_pass.ota_pend),
    .ota_busy                    (cur_pass.ota_busy),
    .calibration_command_pending (cur_pass.cal_pend),
    .calibration_active          (cur_pass.cal_act),
    .evaluation_command_pending  (cur_pass.eval_pend),
    .evaluation_active           (cur_pass.eval_act),
    .out_valid                   (out_valid),
    .out_ready                   (out_ready),
    .mode                        (mode),
    .pump_on                     (pump_on),
    .pulses_done                 (pulses_done),
    .fault                       (fault),
    .available                   (available),
    .report_due                  (report_due)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // back to idle with no pulses and no fault
  function automatic void clear_cycle();
    ctl_mode   = MODE_IDLE;
    ctl_pulses = '0;
    ctl_fault  = FAULT_NONE;
  endfunction

  // advance the controller by one pass and return its status item
  function automatic result_t water_step(pass_t p);
    result_t        r;
    logic           report;
    logic           inhibit;
    logic [PCT_W:0] stop_pct;
    report = 1'b0;
    // emergency stop latches until reset
    if (p.estop && ctl_mode != MODE_ESTOP) begin
      ctl_mode = MODE_ESTOP;
      report   = 1'b1;
    end
    // end of a pump pulse
    if (ctl_mode == MODE_WATER && DUR_W'(p.now - ctl_pulse_t0) >= pulse_ms) begin
      if (ctl_pulses != COUNT_MAX) ctl_pulses = ctl_pulses + 1'b1;
      ctl_soak_t0 = p.now;
      ctl_mode    = MODE_SOAK;
      report      = 1'b1;
    end
    // pending service commands cancel a running cycle
    if ((p.ota_pend || p.cal_pend || p.eval_pend) &&
        (ctl_mode == MODE_WATER || ctl_mode == MODE_SOAK)) begin
      clear_cycle();
      report = 1'b1;
    end
    inhibit = p.ota_busy || p.ota_pend || p.cal_act || p.cal_pend || p.eval_act || p.eval_pend;
    // sample due: soak or lockout decision, then automatic start
    if (!ctl_sampled || DUR_W'(p.now - ctl_sample_t0) >= interval_ms) begin
      stop_pct = {1'b0, thr_pct} + hyst_pct;
      if (stop_pct > PCT_MAX) stop_pct = PCT_MAX;
      ctl_sample_t0 = p.now;
      ctl_sampled   = 1'b1;
      if (ctl_mode == MODE_SOAK && DUR_W'(p.now - ctl_soak_t0) >= soak_ms) begin
        if ({1'b0, p.moist} >= stop_pct) begin
          clear_cycle();
        end else if (ctl_pulses >= limit_cnt) begin
          ctl_mode  = MODE_LOCK;
          ctl_fault = FAULT_LIMIT;
        end else if (ctl_pulses >= RISE_PULSES &&
                     {1'b0, p.moist} < {1'b0, ctl_start_pct} + rise_pct) begin
          ctl_mode  = MODE_LOCK;
          ctl_fault = FAULT_NORISE;
        end else begin
          ctl_mode     = MODE_WATER;
          ctl_pulse_t0 = p.now;
        end
      end else if (ctl_mode == MODE_LOCK && {1'b0, p.moist} >= stop_pct) begin
        clear_cycle();
      end
      if (auto_en && !inhibit && ctl_mode == MODE_IDLE && p.moist < thr_pct) begin
        ctl_start_pct = p.moist;
        ctl_pulses    = '0;
        ctl_fault     = FAULT_NONE;
        ctl_mode      = MODE_WATER;
        ctl_pulse_t0  = p.now;
      end
      report = 1'b1;
    end
    r.mode        = ctl_mode;
    r.pump_on     = (ctl_mode == MODE_WATER);
    r.pulses_done = ctl_pulses;
    r.fault       = ctl_fault;
    r.available   = (ctl_mode == MODE_IDLE || ctl_mode == MODE_LOCK);
    r.report_due  = report;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  // write one register through the port and into the predictor copy
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_START_THRESHOLD: thr_pct     = val[PCT_W-1:0];
      CFG_STOP_HYSTERESIS: hyst_pct    = val[PCT_W-1:0];
      CFG_PULSE_TIME:      pulse_ms    = val[DUR_W-1:0];
      CFG_SOAK_TIME:       soak_ms     = val[DUR_W-1:0];
      CFG_PULSE_LIMIT:     limit_cnt   = val[COUNT_W-1:0];
      CFG_MIN_RISE:        rise_pct    = val[PCT_W-1:0];
      CFG_SAMPLE_INTERVAL: interval_ms = val[DUR_W-1:0];
      CFG_AUTO_ENABLE:     auto_en     = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] thr, logic [31:0] hyst, logic [31:0] pulse,
                            logic [31:0] soak, logic [31:0] limit, logic [31:0] rise,
                            logic [31:0] interval, logic [31:0] auto_on);
    write_reg(CFG_START_THRESHOLD, thr);
    write_reg(CFG_STOP_HYSTERESIS, hyst);
    write_reg(CFG_PULSE_TIME, pulse);
    write_reg(CFG_SOAK_TIME, soak);
    write_reg(CFG_PULSE_LIMIT, limit);
    write_reg(CFG_MIN_RISE, rise);
    write_reg(CFG_SAMPLE_INTERVAL, interval);
    write_reg(CFG_AUTO_ENABLE, auto_on);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every pass is accepted and every status item has come back
  task automatic drain();
    while (pass_q.size() != 0 || in_valid || status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // random passes: time creeps forward, readings cluster around the start and stop levels
  task automatic queue_random(int count, int unsigned step_max, logic estop_on);
    pass_t       p;
    int unsigned lo;
    int unsigned hi;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 39) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, step_max);
      p.now = clock_ms;
      lo = (thr_pct > 15) ? thr_pct - 15 : 0;
      hi = thr_pct + hyst_pct + 5;
      if (hi > 127) hi = 127;
      case ($urandom_range(0, 19))
        0:             p.moist = PCT_W'($urandom_range(0, 127));
        1, 2, 3, 4, 5: p.moist = PCT_W'($urandom_range(0, 100));
        default:       p.moist = PCT_W'($urandom_range(lo, hi));
      endcase
      p.estop     = estop_on && ($urandom_range(0, 9) == 0);
      p.ota_pend  = ($urandom_range(0, 39) == 0);
      p.ota_busy  = ($urandom_range(0, 39) == 0);
      p.cal_pend  = ($urandom_range(0, 39) == 0);
      p.cal_act   = ($urandom_range(0, 39) == 0);
      p.eval_pend = ($urandom_range(0, 39) == 0);
      p.eval_act  = ($urandom_range(0, 39) == 0);
      pass_q.push_back(p);
    end
  endtask

  // driver: predicts on acceptance, then loads the next pass in bursts
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) status_q.push_back(water_step(cur_pass));
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || pass_q.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          cur_pass <= pass_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // monitor: rotating stall pattern and field checks
  always @(posedge clk) begin
    out_ready <= stall_pat[0];
    if (pat_step == 15) begin
      stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
      pat_step  <= 0;
    end else begin
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
      pat_step  <= pat_step + 1;
    end
    if (!rst && out_valid && out_ready) begin
      if (status_q.size() == 0) begin
        $display("%0t: status item with none expected, expected nothing, actual mode %0d",
                 $time, mode);
        errors++;
      end else begin
        want = status_q.pop_front();
        check_field("mode", want.mode, mode);
        check_field("pump_on", want.pump_on, pump_on);
        check_field("pulses_done", want.pulses_done, pulses_done);
        check_field("fault", want.fault, fault);
        check_field("available", want.available, available);
        check_field("report_due", want.report_due, report_due);
      end
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // stimulus phases
  initial begin
    thr_pct       = START_THRESHOLD_RST;
    hyst_pct      = STOP_HYSTERESIS_RST;
    pulse_ms      = PULSE_TIME_RST;
    soak_ms       = SOAK_TIME_RST;
    limit_cnt     = PULSE_LIMIT_RST;
    rise_pct      = MIN_RISE_RST;
    interval_ms   = SAMPLE_INTERVAL_RST;
    auto_en       = AUTO_ENABLE_RST;
    ctl_mode      = MODE_IDLE;
    ctl_pulses    = '0;
    ctl_fault     = FAULT_NONE;
    ctl_pulse_t0  = '0;
    ctl_soak_t0   = '0;
    ctl_sample_t0 = '0;
    ctl_start_pct = '0;
    ctl_sampled   = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed cycle at reset settings: first pass, pulses, soaks, no-rise lockout, recovery
    pass_q.push_back({32'd0,      7'd50,  F_NONE});
    pass_q.push_back({32'd100,    7'd30,  F_NONE});
    pass_q.push_back({32'd10000,  7'd30,  F_NONE});
    pass_q.push_back({32'd15000,  7'd30,  F_NONE});
    pass_q.push_back({32'd20000,  7'd31,  F_NONE});
    pass_q.push_back({32'd75000,  7'd35,  F_NONE});
    pass_q.push_back({32'd80000,  7'd35,  F_NONE});
    pass_q.push_back({32'd140000, 7'd35,  F_NONE});
    pass_q.push_back({32'd145000, 7'd35,  F_NONE});
    pass_q.push_back({32'd205000, 7'd32,  F_NONE});
    pass_q.push_back({32'd215000, 7'd49,  F_NONE});
    pass_q.push_back({32'd225000, 7'd50,  F_NONE});
    // inhibits and cancels
    pass_q.push_back({32'd235000, 7'd20,  F_OTA_BUSY});
    pass_q.push_back({32'd245000, 7'd20,  F_NONE});
    pass_q.push_back({32'd246000, 7'd20,  F_CAL_PEND});
    pass_q.push_back({32'd255000, 7'd127, F_CAL_ACT});
    // time wrap across a pulse
    pass_q.push_back({32'hFFFF_FFFF, 7'd10, F_NONE});
    pass_q.push_back({32'h0000_1387, 7'd10, F_NONE});
    pass_q.push_back({32'h0000_1388, 7'd10, F_EVAL_PEND});
    pass_q.push_back({32'h0000_4000, 7'd0,  F_EVAL_ACT});
    pass_q.push_back({32'h0000_8000, 7'd0,  F_OTA_PEND});
    pass_q.push_back({32'h0000_C000, 7'd0,  F_NONE});
    pass_q.push_back({32'h0000_C001, 7'd0,  F_OTA_PEND | F_CAL_PEND | F_EVAL_PEND});
    clock_ms = 32'h0001_0000;
    drain();

    // short timings
    set_config(40, 10, 20, 50, 5, 3, 10, 1);
    queue_random(250, 15, 1'b0);
    drain();

    // zero durations, zero hysteresis, single pulse limit
    set_config(55, 0, 0, 0, 1, 0, 0, 1);
    queue_random(150, 4, 1'b0);
    drain();

    // stop level capped, long cycles up to the largest pulse limit
    set_config(100, 100, 5, 10, 15, 0, 3, 1);
    queue_random(200, 6, 1'b0);
    drain();

    // masked writes: threshold 127, hysteresis 0, pulse limit 0, rise 100
    set_config(32'hFFFF_FFFF, 32'hFFFF_FF80, 3, 3, 32'h0000_0010, 32'h0000_00E4, 2,
               32'hFFFF_FFFE | 32'd1);
    queue_random(80, 5, 1'b0);
    drain();

    // largest durations
    set_config(60, 20, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4, 5, 32'hFFFF_FFFF, 1);
    queue_random(40, 1000, 1'b0);
    drain();

    // random settings, automatic start sometimes off
    for (int ph = 0; ph < 4; ph++) begin
      set_config($urandom_range(0, 110), $urandom_range(0, 60), $urandom_range(0, 40),
                 $urandom_range(0, 80), $urandom_range(0, 15), $urandom_range(0, 20),
                 $urandom_range(0, 25), ($urandom_range(0, 4) != 0) ? 32'd1 : 32'd0);
      queue_random(80, 20, 1'b0);
      drain();
    end

    // emergency stop last, since only reset leaves it
    set_config(45, 10, 10, 20, 6, 3, 8, 1);
    queue_random(60, 10, 1'b1);
    drain();
    repeat (8) @(posedge clk);

    if (errors == 0 && status_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
